@@ hw/rtl/sadd_pkg.sv @@
package sadd_pkg;

	// Default sizes
	localparam int DEF_MSG_DEPTH     = 512;
	localparam int DEF_DISPLAY_CHARS = 8;

	// Port widths
	localparam int S_TDATA_W = 24;  // position (9) + char_code (8), padded
	localparam int S_TUSER_W = 2;   // kind
	localparam int M_TDATA_W = 16;  // upper (6) + lower (8), padded
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 9;

	// Field widths
	localparam int POS_W  = 9;
	localparam int CHAR_W = 8;
	localparam int UPR_W  = 6;
	localparam int LWR_W  = 8;
	localparam int LEN_W  = 9;
	localparam int TDIV_W = 4;

	// Item kinds
	localparam logic [S_TUSER_W-1:0] KIND_LOAD    = 2'd0;
	localparam logic [S_TUSER_W-1:0] KIND_TICK    = 2'd1;
	localparam logic [S_TUSER_W-1:0] KIND_REFRESH = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDE    = 1'd1;

	localparam logic [TDIV_W-1:0] TICK_DIVIDE_RST = 4'd10;

	// Character codes bounding the glyph ranges
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

	typedef struct packed {
		logic [LWR_W-1:0] lower;
		logic [UPR_W-1:0] upper;
	} glyph_t;

	// Font tables
	localparam logic [UPR_W-1:0] ALPHA_HI [26] = '{
		6'h00, 6'h00, 6'h00, 6'h12, 6'h00, 6'h00, 6'h00, 6'h00, 6'h12, 6'h00, 6'h0C,
		6'h00, 6'h15, 6'h09, 6'h00, 6'h00, 6'h08, 6'h08, 6'h09, 6'h12, 6'h00, 6'h24,
		6'h2A, 6'h2D, 6'h15, 6'h24
	};
	localparam logic [LWR_W-1:0] ALPHA_LO [26] = '{
		8'hF7, 8'hBF, 8'h39, 8'h0F, 8'h79, 8'h71, 8'hBD, 8'hF6, 8'h09, 8'h1E, 8'h70,
		8'h38, 8'h36, 8'h36, 8'h3F, 8'hF3, 8'h3F, 8'hF3, 8'h09, 8'h01, 8'h3E, 8'h30,
		8'h36, 8'h00, 8'h00, 8'h09
	};
	localparam logic [UPR_W-1:0] DIGIT_HI [10] = '{
		6'h24, 6'h04, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00
	};
	localparam logic [LWR_W-1:0] DIGIT_LO [10] = '{
		8'h3F, 8'h06, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'h07, 8'hFF, 8'hEF
	};

	// Character code to segment bytes; anything without a glyph is blank
	function automatic glyph_t glyph(input logic [CHAR_W-1:0] c);
		glyph_t g;
		logic [CHAR_W-1:0] ofs_a;
		logic [CHAR_W-1:0] ofs_d;
		g     = '0;
		ofs_a = c - CHAR_UPPER_A;
		ofs_d = c - CHAR_DIGIT_0;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			g.upper = ALPHA_HI[ofs_a[4:0]];
			g.lower = ALPHA_LO[ofs_a[4:0]];
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			g.upper = DIGIT_HI[ofs_d[3:0]];
			g.lower = DIGIT_LO[ofs_d[3:0]];
		end
		return g;
	endfunction

endpackage

@@ hw/rtl/scrolling_alnum_display_driver.sv @@
// Scrolling alphanumeric display driver. Input words carry a kind in s_tuser: load writes one
// character into the message store, tick advances the scroll divider, refresh restarts the
// display at the first character. A refresh, or every tick_divide-th tick while the message is
// longer than the display, sends one display update: one output word per shown character, in
// display order, with m_tlast on the last one. All modulo reduction goes through a single
// subtract-and-compare unit under a small sequencer, and the block takes no input word until it
// has finished the current one. A load reduces its position modulo min(MSG_DEPTH, 512) before
// the write. An update sends its n shown characters at one per cycle from the store's single
// read port while m_tready stays high; a scroll step first reduces the offset modulo
// message_length and advances it by one. The message store is not cleared at reset: load every
// position that message_length covers before use. Configuration writes are accepted every cycle
// and must be made while no update is in flight.
module scrolling_alnum_display_driver #(
	parameter int MSG_DEPTH     = sadd_pkg::DEF_MSG_DEPTH,
	parameter int DISPLAY_CHARS = sadd_pkg::DEF_DISPLAY_CHARS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input words
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sadd_pkg::S_TDATA_W-1:0] s_tdata,   // position[8:0], char_code[16:9], zero
	input  logic [sadd_pkg::S_TUSER_W-1:0] s_tuser,   // kind[1:0]
	// output words
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sadd_pkg::M_TDATA_W-1:0] m_tdata,   // upper_segments[5:0], lower[13:6], zero
	output logic                           m_tlast,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sadd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sadd_pkg::CFG_DAT_W-1:0] cfg_data
);
	import sadd_pkg::*;

	localparam int AW        = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam int CW        = $clog2(DISPLAY_CHARS + 1);
	localparam int DEPTH_CAP = (MSG_DEPTH > 512) ? 512 : MSG_DEPTH;
	localparam logic [LEN_W:0]   DEPTH_CAP_W = (LEN_W + 1)'(DEPTH_CAP);
	localparam logic [LEN_W-1:0] DISP_W      = LEN_W'(DISPLAY_CHARS);
	localparam logic [CW-1:0]    DISP_C      = CW'(DISPLAY_CHARS);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_LOAD_RED = 6'b000010,
		ST_STEP_RED = 6'b000100,
		ST_STEP_INC = 6'b001000,
		ST_RD       = 6'b010000,
		ST_OUT      = 6'b100000
	} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    len_q;
	logic [TDIV_W-1:0]   tdiv_q;
	logic [TDIV_W-1:0]   tick_q;
	logic [TDIV_W-1:0]   tick_nxt;
	logic                scroll_q;
	logic [POS_W-1:0]    off_q;
	logic [POS_W-1:0]    a_q;
	logic [CHAR_W-1:0]   char_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       n_q;
	logic [CHAR_W-1:0]   rdata_q;
	logic                ovalid_q;
	logic                olast_q;
	glyph_t              oglyph_q;

	logic [CHAR_W-1:0]   mem [MSG_DEPTH];

	logic [LEN_W-1:0]    l_eff;
	logic [CW-1:0]       n_eff;
	logic                long_msg;
	logic [POS_W:0]      unit_a;
	logic [POS_W:0]      unit_m;
	logic [POS_W+1:0]    unit_diff;
	logic                unit_ge;
	logic [POS_W:0]      unit_res;
	logic [POS_W-1:0]    res9;
	logic                in_acc;
	logic                out_free;
	logic                last_char;
	logic                rd_en;
	logic                wr_en;
	logic [AW-1:0]       mem_addr;
	logic [POS_W-1:0]    in_pos;
	logic [CHAR_W-1:0]   in_char;

	assign in_pos  = s_tdata[POS_W-1:0];
	assign in_char = s_tdata[POS_W+CHAR_W-1:POS_W];

	// effective length and shown count
	assign l_eff    = ({1'b0, len_q} < DEPTH_CAP_W) ? len_q : DEPTH_CAP_W[LEN_W-1:0];
	assign n_eff    = (l_eff < DISP_W) ? CW'(l_eff) : DISP_C;
	assign long_msg = l_eff > DISP_W;

	// shared subtract-and-compare unit: reduces a value by one modulus per use
	assign unit_a    = {1'b0, a_q} + {{POS_W{1'b0}},
		(state_q == ST_STEP_INC || state_q == ST_RD || state_q == ST_OUT)};
	assign unit_m    = (state_q == ST_LOAD_RED) ? DEPTH_CAP_W : {1'b0, l_eff};
	assign unit_diff = {1'b0, unit_a} - {1'b0, unit_m};
	assign unit_ge   = !unit_diff[POS_W+1];
	assign unit_res  = unit_ge ? unit_diff[POS_W:0] : unit_a;
	assign res9      = unit_res[POS_W-1:0];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign tick_nxt  = tick_q + 1'b1;

	assign out_free  = !ovalid_q || m_tready;
	assign last_char = (CW'(cnt_q + 1'b1) == n_q);

	// store access
	assign rd_en    = (state_q == ST_RD) || (state_q == ST_OUT && out_free && !last_char);
	assign wr_en    = (state_q == ST_LOAD_RED) && !unit_ge;
	assign mem_addr = AW'(a_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[mem_addr] <= char_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			tdiv_q <= TICK_DIVIDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MESSAGE_LENGTH: len_q  <= cfg_data[LEN_W-1:0];
				REG_TICK_DIVIDE:    tdiv_q <= cfg_data[TDIV_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tick_q   <= '0;
			scroll_q <= 1'b0;
			off_q    <= '0;
			a_q      <= '0;
			cnt_q    <= '0;
			n_q      <= '0;
			char_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (s_tuser)
							KIND_LOAD: begin
								a_q     <= in_pos;
								char_q  <= in_char;
								state_q <= ST_LOAD_RED;
							end
							KIND_TICK: begin
								if (tick_nxt == tdiv_q) begin
									tick_q <= '0;
									if (scroll_q && long_msg) begin
										a_q     <= off_q;
										state_q <= ST_STEP_RED;
									end
								end else begin
									tick_q <= tick_nxt;
								end
							end
							KIND_REFRESH: begin
								off_q    <= '0;
								tick_q   <= '0;
								scroll_q <= long_msg;
								a_q      <= '0;
								cnt_q    <= '0;
								n_q      <= n_eff;
								if (l_eff != '0) begin
									state_q <= ST_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_LOAD_RED: begin
					if (unit_ge) begin
						a_q <= res9;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_STEP_RED: begin
					if (unit_ge) begin
						a_q <= res9;
					end else begin
						state_q <= ST_STEP_INC;
					end
				end
				ST_STEP_INC: begin
					off_q    <= res9;
					a_q      <= res9;
					scroll_q <= long_msg;
					cnt_q    <= '0;
					n_q      <= n_eff;
					state_q  <= ST_RD;
				end
				ST_RD: begin
					a_q     <= res9;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						cnt_q <= CW'(cnt_q + 1'b1);
						if (last_char) begin
							state_q <= ST_IDLE;
						end else begin
							a_q <= res9;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			oglyph_q <= glyph(rdata_q);
			olast_q  <= last_char;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {{(M_TDATA_W - UPR_W - LWR_W){1'b0}}, oglyph_q.lower, oglyph_q.upper};

	// store index stays inside the message while an update runs
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_OUT) |-> (a_q < l_eff))
		else $error("store index outside message during update");

	// character count never reaches the shown count mid-update
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_OUT) |-> (cnt_q < n_q))
		else $error("character count overran update");

	// a read is always followed by the output stage
	a_rd_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_OUT))
		else $error("read not followed by output stage");

	// an update only starts on a message with at least one character
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (n_q != '0))
		else $error("update started on empty message");

endmodule

@@ tb/tb_scrolling_alnum_display_driver.sv @@
module tb_scrolling_alnum_display_driver;
	import sadd_pkg::*;

	localparam logic [S_TUSER_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 80;
	localparam int STALL_LIMIT     = 3000;
	localparam int FILL_DEPTH      = 128;

	// Idle modes for both sides of the stream
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// Predicts display updates and checks the output words against them
	class display_scoreboard;
		typedef struct {
			logic [UPR_W-1:0] upper;
			logic [LWR_W-1:0] lower;
			logic             last;
		} segment_word_t;

		logic [CHAR_W-1:0] chars [DEF_MSG_DEPTH];
		int                offset;
		logic [TDIV_W-1:0] ticks;
		bit                scrolling;
		int                msg_len;
		logic [TDIV_W-1:0] tick_div;
		segment_word_t     expected_words [$];
		int                errors;

		function new();
			foreach (chars[i])
				chars[i] = '0;
			offset    = 0;
			ticks     = '0;
			scrolling = 0;
			msg_len   = 0;
			tick_div  = TICK_DIVIDE_RST;
			errors    = 0;
		endfunction

		// Font: {upper, lower} segment bytes; anything not listed is blank
		function logic [UPR_W+LWR_W-1:0] font(logic [CHAR_W-1:0] c);
			case (c)
				"A": return {6'h00, 8'hF7};  "B": return {6'h00, 8'hBF};
				"C": return {6'h00, 8'h39};  "D": return {6'h12, 8'h0F};
				"E": return {6'h00, 8'h79};  "F": return {6'h00, 8'h71};
				"G": return {6'h00, 8'hBD};  "H": return {6'h00, 8'hF6};
				"I": return {6'h12, 8'h09};  "J": return {6'h00, 8'h1E};
				"K": return {6'h0C, 8'h70};  "L": return {6'h00, 8'h38};
				"M": return {6'h15, 8'h36};  "N": return {6'h09, 8'h36};
				"O": return {6'h00, 8'h3F};  "P": return {6'h00, 8'hF3};
				"Q": return {6'h08, 8'h3F};  "R": return {6'h08, 8'hF3};
				"S": return {6'h09, 8'h09};  "T": return {6'h12, 8'h01};
				"U": return {6'h00, 8'h3E};  "V": return {6'h24, 8'h30};
				"W": return {6'h2A, 8'h36};  "X": return {6'h2D, 8'h00};
				"Y": return {6'h15, 8'h00};  "Z": return {6'h24, 8'h09};
				"0": return {6'h24, 8'h3F};  "1": return {6'h04, 8'h06};
				"2": return {6'h00, 8'hDB};  "3": return {6'h00, 8'hCF};
				"4": return {6'h00, 8'hE6};  "5": return {6'h00, 8'hED};
				"6": return {6'h00, 8'hFD};  "7": return {6'h00, 8'h07};
				"8": return {6'h00, 8'hFF};  "9": return {6'h00, 8'hEF};
				default: return '0;
			endcase
		endfunction

		// One display update from the current offset
		function void queue_update();
			int shown;
			logic [UPR_W+LWR_W-1:0] seg;
			segment_word_t w;
			shown     = (msg_len < DEF_DISPLAY_CHARS) ? msg_len : DEF_DISPLAY_CHARS;
			scrolling = msg_len > DEF_DISPLAY_CHARS;
			for (int k = 0; k < shown; k++) begin
				seg     = font(chars[(offset + k) % msg_len]);
				w.upper = seg[UPR_W+LWR_W-1:LWR_W];
				w.lower = seg[LWR_W-1:0];
				w.last  = (k == shown - 1);
				expected_words.push_back(w);
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			if (idx == REG_MESSAGE_LENGTH)
				msg_len = int'(data[LEN_W-1:0]);
			else if (idx == REG_TICK_DIVIDE)
				tick_div = data[TDIV_W-1:0];
		endfunction

		// Accepted input word
		function void take_item(logic [S_TUSER_W-1:0] kind, logic [POS_W-1:0] pos,
				logic [CHAR_W-1:0] code);
			case (kind)
				KIND_LOAD: chars[pos] = code;
				KIND_TICK: begin
					ticks = ticks + 1'b1;
					if (ticks == tick_div) begin
						ticks = '0;
						if (scrolling && msg_len > DEF_DISPLAY_CHARS) begin
							offset = ((offset % msg_len) + 1) % msg_len;
							queue_update();
						end
					end
				end
				KIND_REFRESH: begin
					offset = 0;
					ticks  = '0;
					queue_update();
				end
				default: ;
			endcase
		endfunction

		// Accepted output word against the oldest expectation
		function void check_segments(logic [UPR_W-1:0] upper, logic [LWR_W-1:0] lower,
				logic last);
			segment_word_t w;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word upper %h lower %h last %b", $time,
					upper, lower, last);
				return;
			end
			w = expected_words.pop_front();
			if (w.upper !== upper || w.lower !== lower || w.last !== last) begin
				errors++;
				$display("%0t: mismatch expected upper %h lower %h last %b, got %h %h %b",
					$time, w.upper, w.lower, w.last, upper, lower, last);
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	display_scoreboard sb;
	idle_mode_t        idle_mode = IDLE_NONE;
	bit                long_hold_go = 0;
	bit                long_hold_taken = 0;
	int                hold_left = 0;
	int                quiet_cycles = 0;

	scrolling_alnum_display_driver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Monitor: note accepted words at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				sb.take_item(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W+CHAR_W-1:POS_W]);
			if (m_tvalid && m_tready)
				sb.check_segments(m_tdata[UPR_W-1:0], m_tdata[UPR_W+LWR_W-1:UPR_W], m_tlast);
		end
	end

	// Watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $time, quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_go && !long_hold_taken) begin
				long_hold_taken = 1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (idle_mode == IDLE_RECEIVER)
				m_tready <= ($urandom_range(99) >= 57);
			else if (idle_mode == IDLE_BOTH)
				m_tready <= ($urandom_range(99) >= 13);
			else
				m_tready <= 1'b1;
		end
	end

	function automatic bit sender_idles();
		if (idle_mode == IDLE_SENDER)
			return $urandom_range(99) < 57;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(99) < 13;
		return 0;
	endfunction

	// Offer one input word and wait for it to be taken
	task automatic send_word(logic [S_TUSER_W-1:0] kind, logic [POS_W-1:0] pos,
			logic [CHAR_W-1:0] code);
		@(negedge clk);
		while (sender_idles()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_TDATA_W-POS_W-CHAR_W){1'b0}}, code, pos};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, let every expected word arrive, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Half the characters have glyphs, the rest are any code
	function automatic logic [CHAR_W-1:0] random_char();
		int g;
		if ($urandom_range(1)) begin
			g = $urandom_range(35);
			return CHAR_W'((g < 10) ? CHAR_DIGIT_0 + g : CHAR_UPPER_A + (g - 10));
		end
		return CHAR_W'($urandom_range(255, 1));
	endfunction

	task automatic random_word();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			send_word(KIND_TICK, POS_W'($urandom_range(511)),
				CHAR_W'($urandom_range(255, 1)));
		else if (r < 75)
			send_word(KIND_REFRESH, POS_W'($urandom_range(511)),
				CHAR_W'($urandom_range(255, 1)));
		else if (r < 95)
			send_word(KIND_LOAD, POS_W'($urandom_range(511)), random_char());
		else
			send_word(KIND_UNUSED, POS_W'($urandom_range(511)),
				CHAR_W'($urandom_range(255, 1)));
	endtask

	// Random phases: message length, divider, idle mode, word count
	int         ph_len   [9] = '{60, 10, 128, 9, 3, 0, 25, 100, 16};
	int         ph_div   [9] = '{1, 1, 15, 0, 2, 4, 3, 5, 1};
	idle_mode_t ph_mode  [9] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
		IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
	int         ph_words [9] = '{40, 40, 40, 50, 30, 30, 40, 40, 40};
	logic [CHAR_W-1:0] directed_chars [12] = '{"A", "Z", "0", "9", "@", "[", "/", ":", "a",
		8'hFF, 8'h01, "M"};

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = KIND_LOAD;
		cfg_valid = 1'b0;
		cfg_index = REG_MESSAGE_LENGTH;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, unused kind, glyph range edges, no-step tick
		send_word(KIND_REFRESH, 9'd0, 8'd1);
		send_word(KIND_UNUSED, 9'h1FF, 8'hFF);
		send_word(KIND_TICK, 9'd0, 8'd1);
		for (int i = 0; i < 12; i++)
			send_word(KIND_LOAD, POS_W'(i), directed_chars[i]);
		send_word(KIND_LOAD, 9'h1FF, "K");
		settle();
		write_reg(REG_MESSAGE_LENGTH, 9'd5);
		send_word(KIND_REFRESH, 9'd0, 8'd1);
		settle();
		write_reg(REG_MESSAGE_LENGTH, 9'd8);
		write_reg(REG_TICK_DIVIDE, 9'd1);
		send_word(KIND_REFRESH, 9'd0, 8'd1);
		// message fits the display, so the due step is dropped
		send_word(KIND_TICK, 9'd0, 8'd1);
		settle();
		write_reg(REG_MESSAGE_LENGTH, 9'd12);
		send_word(KIND_REFRESH, 9'd0, 8'd1);
		send_word(KIND_TICK, 9'd0, 8'd1);
		send_word(KIND_TICK, 9'd0, 8'd1);

		// Fill the store up to the longest message used below
		for (int i = 12; i < FILL_DEPTH; i++)
			send_word(KIND_LOAD, POS_W'(i), random_char());

		for (int p = 0; p < 9; p++) begin
			settle();
			idle_mode = ph_mode[p];
			write_reg(REG_MESSAGE_LENGTH, CFG_DAT_W'(ph_len[p]));
			write_reg(REG_TICK_DIVIDE, CFG_DAT_W'(ph_div[p]));
			// receiver holds off while refreshes pile up at the input
			if (p == 6) begin
				long_hold_go = 1;
				repeat (6) send_word(KIND_REFRESH, POS_W'($urandom_range(511)), 8'd1);
			end
			for (int i = 0; i < ph_words[p]; i++)
				random_word();
		end

		settle();
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d expected words never arrived", $time, sb.pending());
		end
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
